// ----- src/wis_pkg.sv -----
// ----------------------------------------------------------------------------
// wis_pkg
// Types and constants shared by the weighted index sampler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wis_pkg;

    localparam int COUNT_W   = 7;   // component_count register
    localparam int WEIGHT_W  = 16;  // weight field
    localparam int CUM_W     = 22;  // cumulative sums and total
    localparam int RND_W     = 32;  // random word
    localparam int OUT_IDX_W = 6;   // chosen_index field

    // remainder unit: radix-16, one digit per cycle
    localparam int MOD_STEP_BITS = 4;
    localparam int MOD_DIGITS    = RND_W / MOD_STEP_BITS;
    localparam int DIGIT_W       = $clog2(MOD_DIGITS);

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SELECT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_MUL,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic               start;
        logic [RND_W-1:0]   dividend;
        logic [COUNT_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] rem;
    } mod_rsp_t;

endpackage

`default_nettype wire

// ----- src/wis_table_ram.sv -----
// ----------------------------------------------------------------------------
// wis_table_ram
// Cumulative weight table: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wis_table_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 22
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- src/wis_mod_unit.sv -----
// ----------------------------------------------------------------------------
// wis_mod_unit
// Iterative remainder of the random word by the component count, radix 16.
// ----------------------------------------------------------------------------
`default_nettype none

module wis_mod_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wis_pkg::mod_req_t req,
    output wis_pkg::mod_rsp_t      rsp
);

    localparam int RW = wis_pkg::RND_W;
    localparam int CW = wis_pkg::COUNT_W;
    localparam int SB = wis_pkg::MOD_STEP_BITS;
    localparam int DW = wis_pkg::DIGIT_W;

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [DW-1:0] digit_reg, digit_next;
    logic [RW-1:0] dvd_reg, dvd_next;
    logic [CW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] step_rem;

    // SB restoring steps; remainder stays below the divisor
    always_comb
    begin
        logic [CW:0]   trial;
        logic [CW-1:0] r;
        r = rem_reg;
        for (int k = 0; k < SB; k++)
        begin
            trial = {r, dvd_reg[RW-1-k]};
            if (trial >= {1'b0, dvs_reg})
            begin
                r = CW'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                r = trial[CW-1:0];
            end
        end
        step_rem = r;
    end

    always_comb
    begin
        run_next   = run_reg;
        done_next  = 1'b0;
        digit_next = digit_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        if (req.start)
        begin
            run_next   = 1'b1;
            digit_next = '0;
            dvd_next   = req.dividend;
            dvs_next   = req.divisor;
            rem_next   = '0;
        end
        else if (run_reg)
        begin
            rem_next   = step_rem;
            dvd_next   = dvd_reg << SB;
            digit_next = digit_reg + DW'(1);
            if (digit_reg == DW'(wis_pkg::MOD_DIGITS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            digit_reg <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            done_reg  <= done_next;
            digit_reg <= digit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// ----- src/weighted_index_sampler.sv -----
// ----------------------------------------------------------------------------
// weighted_index_sampler
// Roulette-wheel component selection over a table of cumulative weights.
// Load request: taken while idle, no result; loads may follow every cycle while idle.
// Select: done strobes in the cycle after accept when empty or count is 1; in
//   equiprobable mode it follows the radix-16 remainder (8 digits), and in
//   weighted mode the table scan up to chosen index i (one table RAM read per cycle).
// busy is high until the strobe; the next request is taken while it shows.
// Reset is asynchronous: count 64, equiprobable, not empty; table not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_index_sampler #(
    parameter int MAX_COMPONENTS = 64,
    parameter int WEIGHT_BITS    = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        func,
    input  wire logic [15:0] weight,
    input  wire logic [21:0] weight_total,
    input  wire logic        last_weight,
    input  wire logic [31:0] random_word,
    output logic             done,
    output logic [5:0]       chosen_index,
    output logic             mixture_empty
);

    localparam int CW    = wis_pkg::COUNT_W;
    localparam int WB    = wis_pkg::WEIGHT_W;
    localparam int SW    = wis_pkg::CUM_W;
    localparam int RW    = wis_pkg::RND_W;
    localparam int OW    = wis_pkg::OUT_IDX_W;
    localparam int PW    = RW + SW;
    localparam int IDX_W = $clog2(MAX_COMPONENTS);
    localparam int POS_W = $clog2(MAX_COMPONENTS + 1);
    localparam int CMP_W = (IDX_W > CW) ? IDX_W : CW;

    localparam logic [CW-1:0] MAX_CNT = (MAX_COMPONENTS > (1 << CW) - 1) ?
                                        {CW{1'b1}} : CW'(MAX_COMPONENTS);
    localparam logic [WB-1:0] WMASK   = (WEIGHT_BITS >= WB) ?
                                        {WB{1'b1}} : WB'((1 << WEIGHT_BITS) - 1);

    wis_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [SW-1:0]     total_reg, total_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              weighted_reg, weighted_next;
    logic              empty_reg, empty_next;
    logic              done_reg, done_next;

    logic [RW-1:0]     rnd_reg, rnd_next;
    logic [SW-1:0]     run_sum_reg, run_sum_next;
    logic [SW-1:0]     target_reg, target_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [OW-1:0]     chosen_index_reg, chosen_index_next;
    logic              mixture_empty_reg, mixture_empty_next;

    logic [CW-1:0]     count_eff;
    logic [CMP_W-1:0]  last_cmp;
    logic [SW-1:0]     prev_sum;
    logic [SW:0]       sum_wide;
    logic [SW-1:0]     sum_sat;
    logic [PW-1:0]     product;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  ram_raddr;
    logic [SW-1:0]     ram_rdata;

    wis_pkg::mod_req_t mod_req;
    wis_pkg::mod_rsp_t mod_rsp;

    wis_table_ram #(
        .DEPTH  (MAX_COMPONENTS),
        .ADDR_W (IDX_W),
        .DATA_W (SW)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (sum_sat),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    wis_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // count 0 acts as 1, large counts clamp to the table depth
    always_comb
    begin
        if (count_reg == '0)
        begin
            count_eff = CW'(1);
        end
        else if (count_reg > MAX_CNT)
        begin
            count_eff = MAX_CNT;
        end
        else
        begin
            count_eff = count_reg;
        end
    end

    assign last_cmp  = CMP_W'(count_eff) - CMP_W'(1);
    assign prev_sum  = (pos_reg == '0) ? '0 : run_sum_reg;
    assign sum_wide  = {1'b0, prev_sum} + (SW + 1)'(weight & WMASK);
    assign sum_sat   = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
    assign product   = PW'(rnd_reg) * PW'(total_reg);
    assign ram_waddr = IDX_W'(pos_reg);

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        total_next         = total_reg;
        pos_next           = pos_reg;
        weighted_next      = weighted_reg;
        empty_next         = empty_reg;
        done_next          = 1'b0;
        rnd_next           = rnd_reg;
        run_sum_next       = run_sum_reg;
        target_next        = target_reg;
        cmp_idx_next       = cmp_idx_reg;
        chosen_index_next  = chosen_index_reg;
        mixture_empty_next = mixture_empty_reg;
        ram_we             = 1'b0;
        ram_raddr          = cmp_idx_reg + IDX_W'(1);  // speculative next entry
        mod_req.start      = 1'b0;
        mod_req.dividend   = random_word;
        mod_req.divisor    = count_eff;

        if (cfg_write)
        begin
            count_next = cfg_data;
        end

        unique case (state_reg)
            wis_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (func == wis_pkg::FUNC_LOAD)
                    begin
                        if (pos_reg < POS_W'(MAX_COMPONENTS))
                        begin
                            ram_we       = 1'b1;
                            run_sum_next = sum_sat;
                            pos_next     = pos_reg + POS_W'(1);
                        end
                        if (last_weight)
                        begin
                            total_next = weight_total;
                            pos_next   = '0;
                            if (weight_total == '0)
                            begin
                                empty_next = 1'b1;
                            end
                            else
                            begin
                                empty_next    = 1'b0;
                                weighted_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        rnd_next = random_word;
                        if (empty_reg)
                        begin
                            done_next          = 1'b1;
                            chosen_index_next  = '0;
                            mixture_empty_next = 1'b1;
                        end
                        else if (count_eff == CW'(1))
                        begin
                            done_next          = 1'b1;
                            chosen_index_next  = '0;
                            mixture_empty_next = 1'b0;
                        end
                        else if (!weighted_reg)
                        begin
                            mod_req.start = 1'b1;
                            state_next    = wis_pkg::ST_MOD;
                        end
                        else
                        begin
                            state_next = wis_pkg::ST_MUL;
                        end
                    end
                end
            end

            wis_pkg::ST_MOD:
            begin
                if (mod_rsp.done)
                begin
                    done_next          = 1'b1;
                    chosen_index_next  = OW'(mod_rsp.rem);
                    mixture_empty_next = 1'b0;
                    state_next         = wis_pkg::ST_IDLE;
                end
            end

            wis_pkg::ST_MUL:
            begin
                target_next  = product[PW-1:RW];
                cmp_idx_next = '0;
                ram_raddr    = '0;
                state_next   = wis_pkg::ST_SCAN;
            end

            wis_pkg::ST_SCAN:
            begin
                // first sum at or above target; the last entry catches a miss
                if ((ram_rdata >= target_reg) || (CMP_W'(cmp_idx_reg) == last_cmp))
                begin
                    done_next          = 1'b1;
                    chosen_index_next  = OW'(cmp_idx_reg);
                    mixture_empty_next = 1'b0;
                    state_next         = wis_pkg::ST_IDLE;
                end
                else
                begin
                    cmp_idx_next = cmp_idx_reg + IDX_W'(1);
                end
            end

            default:
            begin
                state_next = wis_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= wis_pkg::ST_IDLE;
            count_reg    <= CW'(64);
            total_reg    <= '0;
            pos_reg      <= '0;
            weighted_reg <= 1'b0;
            empty_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            pos_reg      <= pos_next;
            weighted_reg <= weighted_next;
            empty_reg    <= empty_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg           <= rnd_next;
        run_sum_reg       <= run_sum_next;
        target_reg        <= target_next;
        cmp_idx_reg       <= cmp_idx_next;
        chosen_index_reg  <= chosen_index_next;
        mixture_empty_reg <= mixture_empty_next;
    end

    assign busy          = (state_reg != wis_pkg::ST_IDLE);
    assign done          = done_reg;
    assign chosen_index  = chosen_index_reg;
    assign mixture_empty = mixture_empty_reg;

`ifndef ASSERT_OFF
    a_empty_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mixture_empty) |-> (chosen_index == '0))
        else $error("empty result with nonzero index");

    a_scan_mode: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == wis_pkg::ST_MUL) || (state_reg == wis_pkg::ST_SCAN))
        |-> (weighted_reg && !empty_reg))
        else $error("table scan outside weighted mode");

    a_mod_owner: assert property (@(posedge clk) disable iff (!rst_n)
        mod_rsp.done |-> (state_reg == wis_pkg::ST_MOD))
        else $error("remainder result with no select waiting");

    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (total_reg == '0))
        else $error("empty flag with nonzero total");

    a_weighted_total: assert property (@(posedge clk) disable iff (!rst_n)
        (weighted_reg && !empty_reg) |-> (total_reg != '0))
        else $error("weighted mode with zero total");
`endif

endmodule

`default_nettype wire
